>>> rtl/ptb_pkg.sv
// Package for the periodic timer bank: default sizes, input kinds, FSM states
// and the result record passed between the sequencer and the output register.
// No dependencies.
package ptb_pkg;

  localparam int DEF_NUM_SLOTS  = 16;
  localparam int DEF_TICK_WIDTH = 16;

  // At most this many results are reported for one tick.
  localparam int MAX_RESULTS = 16;
  localparam int EMIT_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_PROGRAM = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_FLUSH
  } ptb_state_t;

  typedef struct packed {
    logic [3:0] fired_slot;
    logic       expired;
    logic       last;
  } ptb_result_t;

endpackage

>>> rtl/ptb_slot_ram.sv
// Slot table memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module ptb_slot_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ptb_out_reg.sv
// Output register for the result channel; accepts a new result whenever it is
// empty or its current result is being taken. Depends on ptb_pkg.
module ptb_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ptb_pkg::ptb_result_t push_data,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_fired_slot,
  output logic                out_expired,
  output logic                out_last
);
  import ptb_pkg::*;

  logic        valid_r;
  ptb_result_t data_r;

  assign ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_valid      = valid_r;
  assign out_fired_slot = data_r.fired_slot;
  assign out_expired    = data_r.expired;
  assign out_last       = data_r.last;

endmodule

>>> rtl/periodic_timer_bank.sv
// Periodic timer bank top level: sweep sequencer over the slot table memory.
// Depends on ptb_pkg, ptb_slot_ram and ptb_out_reg.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  kind, slot, initial_delay,
//                                         reload_period, repeat_count
//  out_     output     out_valid/out_stall fired_slot, expired, last
//
// A program transaction writes the slot entry directly (a zero repeat count
// only clears its active flag). A tick sweeps all slots: ST_READ skips an
// inactive slot or reads an active one, ST_UPDATE updates and writes it back,
// ST_FLUSH closes the sweep. The active flags live in flip-flops cleared by
// reset; no memory clearing is needed. Each firing holds one result back so
// the final one can be flagged; a stalled output register stalls the sweep.
module periodic_timer_bank #(
  parameter int NUM_SLOTS  = ptb_pkg::DEF_NUM_SLOTS,
  parameter int TICK_WIDTH = ptb_pkg::DEF_TICK_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_initial_delay,
  input  logic [15:0] in_reload_period,
  input  logic [15:0] in_repeat_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_fired_slot,
  output logic        out_expired,
  output logic        out_last
);
  import ptb_pkg::*;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int DATA_W = 2 * TICK_WIDTH + 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  ptb_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0]   active_r, active_nxt;
  ptb_result_t            pend_r, pend_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [EMIT_CNT_W-1:0]  emit_cnt_r, emit_cnt_nxt;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr;
  logic [DATA_W-1:0]      ram_wdata, ram_rdata;

  logic                   push, buf_ready;
  ptb_result_t            push_data;

  // Input fields narrowed or widened to the tick width.
  logic [TICK_WIDTH+15:0] delay_ext, period_ext;
  logic [TICK_WIDTH-1:0]  in_delay, in_period;
  logic [IDX_W+3:0]       slot_ext;
  logic [IDX_W-1:0]       in_addr;
  logic                   slot_ok;
  logic [IDX_W+3:0]       idx_ext;

  assign delay_ext  = {{TICK_WIDTH{1'b0}}, in_initial_delay};
  assign period_ext = {{TICK_WIDTH{1'b0}}, in_reload_period};
  assign in_delay   = delay_ext[TICK_WIDTH-1:0];
  assign in_period  = period_ext[TICK_WIDTH-1:0];
  assign slot_ext   = {{IDX_W{1'b0}}, in_slot};
  assign in_addr    = slot_ext[IDX_W-1:0];
  assign slot_ok    = (32'(in_slot) < 32'(NUM_SLOTS));
  assign idx_ext    = {4'b0000, idx_r};

  // Entry read back from memory: {period, count, ticks left}.
  logic [TICK_WIDTH-1:0]  rd_period, rd_ticks, ticks_dec, ticks_new;
  logic [15:0]            rd_count, count_new;
  logic                   fire, positive, done, emit, blocked;

  assign rd_period = ram_rdata[DATA_W-1 -: TICK_WIDTH];
  assign rd_count  = ram_rdata[TICK_WIDTH +: 16];
  assign rd_ticks  = ram_rdata[TICK_WIDTH-1:0];

  always_comb begin
    ticks_dec = (rd_ticks != '0) ? rd_ticks - 1'b1 : rd_ticks;
    fire      = (ticks_dec == '0);
    positive  = (rd_count != 16'd0) && !rd_count[15];
    count_new = (fire && positive) ? rd_count - 16'd1 : rd_count;
    done      = fire && positive && (count_new == 16'd0);
    ticks_new = (fire && !done) ? rd_period : ticks_dec;
    emit      = fire && (emit_cnt_r < EMIT_CNT_W'(MAX_RESULTS));
    // A new firing needs the held result to move out first.
    blocked   = emit && pend_v_r && !buf_ready;
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    active_nxt   = active_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    emit_cnt_nxt = emit_cnt_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = {rd_period, count_new, ticks_new};
    push         = 1'b0;
    push_data    = pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_TICK) begin
            idx_nxt      = '0;
            emit_cnt_nxt = '0;
            state_nxt    = ST_READ;
          end else if (slot_ok) begin
            ram_waddr = in_addr;
            ram_wdata = {in_period, in_repeat_count, in_delay};
            if (in_repeat_count == 16'd0) begin
              active_nxt[in_addr] = 1'b0;
            end else begin
              active_nxt[in_addr] = 1'b1;
              ram_we              = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        if (active_r[idx_r]) begin
          ram_re    = 1'b1;
          state_nxt = ST_UPDATE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        if (!blocked) begin
          ram_we = 1'b1;
          if (done) begin
            active_nxt[idx_r] = 1'b0;
          end
          if (emit) begin
            push         = pend_v_r;
            pend_nxt     = '{fired_slot: idx_ext[3:0], expired: done, last: 1'b0};
            pend_v_nxt   = 1'b1;
            emit_cnt_nxt = emit_cnt_r + 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (buf_ready) begin
          push       = 1'b1;
          push_data  = '{fired_slot: pend_r.fired_slot, expired: pend_r.expired,
                         last: 1'b1};
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      active_r   <= '0;
      pend_v_r   <= 1'b0;
      idx_r      <= '0;
      emit_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      pend_v_r   <= pend_v_nxt;
      idx_r      <= idx_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  ptb_slot_ram #(
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  ptb_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_data      (push_data),
    .ready          (buf_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fired_slot (out_fired_slot),
    .out_expired    (out_expired),
    .out_last       (out_last)
  );

endmodule
